[sv/gbi_pkg.sv]
package gbi_pkg;

  // fixed field widths
  localparam int unsigned COORD_BITS = 20;
  localparam int unsigned WADDR_BITS = 12;
  localparam int unsigned CFG_BITS   = 13;

  // defaults for the top level parameters
  localparam int unsigned GRID_DEPTH_DEF  = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  // row stride after reset
  localparam logic [CFG_BITS-1:0] GRID_WIDTH_RST = 13'd64;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_CHECK,
    S_RD10,
    S_RD01,
    S_RD11,
    S_LERPB,
    S_BOT,
    S_LERPY,
    S_FINAL
  } state_e;

  // neighbour read select
  typedef enum logic [1:0] {
    RD_A00,
    RD_A10,
    RD_A01,
    RD_A11
  } rd_sel_e;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_TOP,
    MUL_BOT,
    MUL_Y
  } mul_sel_e;

  // adder operand select
  typedef enum logic [1:0] {
    ADD_TOP,
    ADD_BOT,
    ADD_RES
  } add_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     mem_we;
    logic     load_req;
    logic     calc_base;
    logic     calc_check;
    rd_sel_e  rd_sel;
    logic     cap_s00;
    logic     cap_s01;
    logic     mul_en;
    mul_sel_e mul_sel;
    add_sel_e add_sel;
    logic     top_en;
    logic     bot_en;
    logic     res_en;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic oor;
  } status_t;

endpackage

[sv/gbi_if.sv]
interface gbi_req_if #(
  parameter int unsigned SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF
);
  import gbi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [COORD_BITS-1:0]        x_coord;
  logic [COORD_BITS-1:0]        y_coord;
  logic [WADDR_BITS-1:0]        write_addr;
  logic signed [SAMPLE_BITS-1:0] write_value;

  modport source (
    output valid, req_type, x_coord, y_coord, write_addr, write_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, x_coord, y_coord, write_addr, write_value,
    output ready
  );
endinterface

interface gbi_rsp_if #(
  parameter int unsigned SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          out_of_range;

  modport source (
    output valid, value, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, value, out_of_range,
    output ready
  );
endinterface

[sv/gbi_ctrl.sv]
module gbi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_type_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gbi_pkg::status_t  status_i,
  output gbi_pkg::cmd_t     cmd_o
);
  import gbi_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel  = RD_A00;
    cmd_o.mul_sel = MUL_TOP;
    cmd_o.add_sel = ADD_TOP;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_type_i == REQ_WRITE) begin
            cmd_o.mem_we = 1'b1;
          end else begin
            cmd_o.load_req = 1'b1;
            state_d        = S_BASE;
          end
        end
      end
      S_BASE: begin
        cmd_o.calc_base = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.calc_check = 1'b1;
        cmd_o.rd_sel     = RD_A00;
        state_d          = status_i.oor ? S_FINAL : S_RD10;
      end
      S_RD10: begin
        cmd_o.cap_s00 = 1'b1;
        cmd_o.rd_sel  = RD_A10;
        state_d       = S_RD01;
      end
      S_RD01: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TOP;
        cmd_o.rd_sel  = RD_A01;
        state_d       = S_RD11;
      end
      S_RD11: begin
        cmd_o.cap_s01 = 1'b1;
        cmd_o.add_sel = ADD_TOP;
        cmd_o.top_en  = 1'b1;
        cmd_o.rd_sel  = RD_A11;
        state_d       = S_LERPB;
      end
      S_LERPB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BOT;
        state_d       = S_BOT;
      end
      S_BOT: begin
        cmd_o.add_sel = ADD_BOT;
        cmd_o.bot_en  = 1'b1;
        state_d       = S_LERPY;
      end
      S_LERPY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y;
        state_d       = S_FINAL;
      end
      S_FINAL: begin
        cmd_o.add_sel = ADD_RES;
        // load the output register once it is free or draining
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_en = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/gbi_datapath.sv]
module gbi_datapath #(
  parameter int unsigned GRID_DEPTH  = gbi_pkg::GRID_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = gbi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gbi_pkg::cmd_t                     cmd_i,
  output gbi_pkg::status_t                  status_o,
  input  logic                              cfg_we_i,
  input  logic [gbi_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  input  logic [gbi_pkg::COORD_BITS-1:0]    x_coord_i,
  input  logic [gbi_pkg::COORD_BITS-1:0]    y_coord_i,
  input  logic [gbi_pkg::WADDR_BITS-1:0]    write_addr_i,
  input  logic signed [SAMPLE_BITS-1:0]     write_value_i,
  output logic signed [SAMPLE_BITS-1:0]     value_o,
  output logic                              out_of_range_o
);
  import gbi_pkg::*;

  localparam int unsigned AW     = $clog2(GRID_DEPTH);
  localparam int unsigned IB     = COORD_BITS - FRAC_BITS;
  localparam int unsigned BASE_W = IB + CFG_BITS;
  localparam int unsigned ADDR_W = BASE_W + 1;
  localparam int unsigned DW     = SAMPLE_BITS + 1;
  localparam int unsigned PW     = DW + FRAC_BITS + 1;

  // configuration register
  logic [CFG_BITS-1:0] grid_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= GRID_WIDTH_RST;
    end else if (cfg_we_i) begin
      grid_width_q <= cfg_wdata_i;
    end
  end

  // query coordinates
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [IB-1:0]         x0, y0;
  logic [IB:0]           x1;
  logic [FRAC_BITS-1:0]  fx, fy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      x_q <= x_coord_i;
      y_q <= y_coord_i;
    end
  end

  assign x0 = x_q[COORD_BITS-1:FRAC_BITS];
  assign y0 = y_q[COORD_BITS-1:FRAC_BITS];
  assign fx = x_q[FRAC_BITS-1:0];
  assign fy = y_q[FRAC_BITS-1:0];
  assign x1 = {1'b0, x0} + (IB+1)'(fx != '0);

  // row bases and range check
  logic [BASE_W-1:0] base0_q, base1_q, base1_d;
  logic [ADDR_W-1:0] a11;
  logic              oor_d, oor_q;

  always_comb begin
    base1_d = base0_q + ((fy != '0) ? BASE_W'(grid_width_q) : '0);
    a11     = ADDR_W'(x1) + ADDR_W'(base1_d);
    oor_d   = (ADDR_W'(x1) >= ADDR_W'(grid_width_q)) || (a11 >= ADDR_W'(GRID_DEPTH));
  end

  assign status_o.oor = oor_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_base) begin
      base0_q <= BASE_W'(y0) * BASE_W'(grid_width_q);
    end
    if (cmd_i.calc_check) begin
      base1_q <= base1_d;
      oor_q   <= oor_d;
    end
  end

  // neighbour address select
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_A00:  rd_addr = ADDR_W'(x0) + ADDR_W'(base0_q);
      RD_A10:  rd_addr = ADDR_W'(x1) + ADDR_W'(base0_q);
      RD_A01:  rd_addr = ADDR_W'(x0) + ADDR_W'(base1_q);
      RD_A11:  rd_addr = ADDR_W'(x1) + ADDR_W'(base1_q);
      default: rd_addr = '0;
    endcase
  end

  // single port grid memory, registered read
  logic [SAMPLE_BITS-1:0]        grid_mem_q [GRID_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic                          wr_ok;

  assign wr_ok = 32'(write_addr_i) < 32'(GRID_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      if (wr_ok) begin
        grid_mem_q[AW'(write_addr_i)] <= write_value_i;
      end
    end else begin
      rdata_q <= $signed(grid_mem_q[AW'(rd_addr)]);
    end
  end

  // captured neighbours and partial results
  logic signed [SAMPLE_BITS-1:0] s00_q, s01_q, top_q, bot_q;

  // shared multiplier: (b - a) * f
  logic signed [DW-1:0]  mul_diff;
  logic [FRAC_BITS-1:0]  mul_f;
  logic signed [PW-1:0]  prod_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_TOP: begin
        mul_diff = DW'(rdata_q) - DW'(s00_q);
        mul_f    = fx;
      end
      MUL_BOT: begin
        mul_diff = DW'(rdata_q) - DW'(s01_q);
        mul_f    = fx;
      end
      MUL_Y: begin
        mul_diff = DW'(bot_q) - DW'(top_q);
        mul_f    = fy;
      end
      default: begin
        mul_diff = '0;
        mul_f    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PW'(mul_diff) * PW'($signed({1'b0, mul_f}));
    end
  end

  // shared adder: a + floor(product / 2^frac)
  logic signed [PW-1:0]          prod_sh;
  logic signed [SAMPLE_BITS-1:0] add_a, add_sum;

  always_comb begin
    unique case (cmd_i.add_sel)
      ADD_TOP: add_a = s00_q;
      ADD_BOT: add_a = s01_q;
      ADD_RES: add_a = top_q;
      default: add_a = '0;
    endcase
    prod_sh = prod_q >>> FRAC_BITS;
    add_sum = add_a + $signed(prod_sh[SAMPLE_BITS-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_s00) begin
      s00_q <= rdata_q;
    end
    if (cmd_i.cap_s01) begin
      s01_q <= rdata_q;
    end
    if (cmd_i.top_en) begin
      top_q <= add_sum;
    end
    if (cmd_i.bot_en) begin
      bot_q <= add_sum;
    end
  end

  // output register
  logic signed [SAMPLE_BITS-1:0] value_q;
  logic                          flag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      value_q <= oor_q ? '0 : add_sum;
      flag_q  <= oor_q;
    end
  end

  assign value_o        = value_q;
  assign out_of_range_o = flag_q;

endmodule

[sv/grid_bilinear_interpolator.sv]
// Bilinear interpolator over a row-major grid of signed samples.
// Request channel (req_i): req_type selects a write (store write_value at
// write_addr, no response) or a query (x_coord, y_coord with fraction bits).
// Response channel (rsp_o): one transfer per query with the interpolated
// value, or value 0 and out_of_range set when the ceiling column reaches the
// row width or the far corner address falls outside the store.
// Configuration: cfg_we_i writes cfg_wdata_i into the row width (reset 64).
// Write it only while no query is in flight; the block does not enforce this.
// Sequencing: a write is stored as it is taken and the request channel stays
// ready; a query holds the request channel until it is finished (row base
// multiply, range check, four reads through the single port grid memory,
// three interpolations on one shared multiplier). An out of range query
// goes from the range check straight to the result.
// The response sits in an output register, so a new request is taken while
// the previous response waits; a stalled receiver only holds a finished query
// in its last step. Reset clears control state and sets the row width to 64;
// the grid contents stay undefined until written.
module grid_bilinear_interpolator #(
  parameter int unsigned GRID_DEPTH  = gbi_pkg::GRID_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = gbi_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = gbi_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gbi_req_if.sink                      req_i,
  gbi_rsp_if.source                    rsp_o,
  input  logic                         cfg_we_i,
  input  logic [gbi_pkg::CFG_BITS-1:0] cfg_wdata_i
);
  import gbi_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  gbi_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_req_type_i (req_i.req_type),
    .in_ready_o    (req_i.ready),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // grid memory and arithmetic
  gbi_datapath #(
    .GRID_DEPTH  (GRID_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .x_coord_i      (req_i.x_coord),
    .y_coord_i      (req_i.y_coord),
    .write_addr_i   (req_i.write_addr),
    .write_value_i  (req_i.write_value),
    .value_o        (rsp_o.value),
    .out_of_range_o (rsp_o.out_of_range)
  );

endmodule
